// ----- rtl/core/json_key_string_extractor_top_macros.svh -----
// Assertion macros for the JSON key string extractor.
// Both sample on the rising clock edge and are disabled during reset.
`ifndef JSON_KEY_STRING_EXTRACTOR_TOP_MACROS_SVH
`define JSON_KEY_STRING_EXTRACTOR_TOP_MACROS_SVH

// Same-cycle implication
`define JKSE_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define JKSE_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/jkse_pkg.sv -----
`timescale 1ns / 1ps
package jkse_pkg;

   // Key storage: two 64-bit registers, sixteen bytes in all
   localparam int KEY_BYTES   = 16;
   localparam int KEY_BITS    = KEY_BYTES * 8;
   localparam int KEY_IDX_W   = 4;
   localparam int KEY_LEN_W   = 5;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_IDX_W   = 2;

   // Result queue
   localparam int Q_DEPTH  = 4;
   localparam int QPTR_W   = 2;
   localparam int QCNT_W   = 3;

   // Characters
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_COLON  = 8'h3A;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QMARK  = 8'h3F;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_B      = 8'h62;
   localparam logic [7:0] CHAR_F      = 8'h66;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_BS     = 8'h08;
   localparam logic [7:0] CHAR_FF     = 8'h0C;

   // Bytes dropped after a \u escape
   localparam logic [2:0] HEX_SKIP = 3'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_LOW  = 2'd0,
      CSR_KEY_HIGH = 2'd1,
      CSR_KEY_LEN  = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      KIND_DATA     = 2'd0,
      KIND_OK       = 2'd1,
      KIND_NOTFOUND = 2'd2,
      KIND_BAD      = 2'd3
   } kind_type;

   typedef enum logic [6:0] {
      PH_SEARCH = 7'b0000001,
      PH_COLON  = 7'b0000010,
      PH_OPENQ  = 7'b0000100,
      PH_VALUE  = 7'b0001000,
      PH_ESC    = 7'b0010000,
      PH_HEX    = 7'b0100000,
      PH_DONE   = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       document_end;
   } req_type;

   typedef struct packed {
      logic [7:0] value_byte;
      kind_type   kind;
      logic       final_item;
   } rsp_type;

   // Window control from the sequencer
   typedef struct packed {
      logic       shift;
      logic       clear;
      logic [7:0] data;
   } win_ctl_type;

   // Window status back to the sequencer
   typedef struct packed {
      logic match;
      logic empty;
   } win_sts_type;

   // Up to two result items pushed per processed item
   typedef struct packed {
      logic [1:0] cnt;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   typedef struct packed {
      logic fire;
      logic last;
      logic searching;
   } core_sts_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) || (c == CHAR_CR);
   endfunction

   function automatic logic [7:0] decode_escape(input logic [7:0] e);
      logic [7:0] r;
      case (e)
         CHAR_B:  r = CHAR_BS;
         CHAR_F:  r = CHAR_FF;
         CHAR_N:  r = CHAR_LF;
         CHAR_R:  r = CHAR_CR;
         CHAR_T:  r = CHAR_TAB;
         default: r = e;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/core/jkse_window.sv -----
`timescale 1ns / 1ps
module jkse_window import jkse_pkg::*; #(
   parameter int MaxKeyBytes = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [KEY_BITS-1:0]  key_all,
   input  logic [KEY_LEN_W-1:0] key_len,
   input  win_ctl_type          ctl,
   output win_sts_type          sts
);

   localparam int WinLen = MaxKeyBytes + 2;
   localparam int SeenW  = $clog2(WinLen + 1);

   logic [7:0]           win_ff [WinLen];
   logic [7:0]           win_in [WinLen];
   logic [SeenW-1:0]     seen_ff;
   logic [SeenW-1:0]     seen_in;
   logic [SeenW-1:0]     klen;
   logic [SeenW-1:0]     plen;
   logic [KEY_IDX_W-1:0] kidx;
   logic [7:0]           want;
   logic                 hit;

   // Shift the new byte in and compare the window against the quoted key
   always_comb begin
      win_in[0] = ctl.data;
      for (int k = 1; k < WinLen; k++) begin
         win_in[k] = win_ff[k-1];
      end
      seen_in = seen_ff;
      if (seen_ff < SeenW'(WinLen)) begin
         seen_in = seen_ff + 1'b1;
      end
      klen = (key_len > KEY_LEN_W'(MaxKeyBytes)) ? SeenW'(MaxKeyBytes) : SeenW'(key_len);
      plen = klen + SeenW'(2);
      hit  = 1'b1;
      kidx = '0;
      want = CHAR_QUOTE;
      for (int q = 0; q < WinLen; q++) begin
         want = CHAR_QUOTE;
         kidx = KEY_IDX_W'(klen - SeenW'(q));
         if (q != 0 && SeenW'(q) != plen - 1'b1) begin
            want = key_all[{kidx, 3'b000} +: 8];
         end
         if (SeenW'(q) < plen && win_in[q] != want) begin
            hit = 1'b0;
         end
      end
   end

   assign sts.match = hit && (seen_in >= plen);
   assign sts.empty = (seen_ff == '0);

   // Count valid window bytes; clear at document end
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (ctl.clear) begin
         seen_ff <= '0;
      end else if (ctl.shift) begin
         seen_ff <= seen_in;
      end
   end

   // Advance the byte window
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         win_ff <= win_in;
      end
   end

endmodule

// ----- rtl/core/jkse_core.sv -----
`timescale 1ns / 1ps
module jkse_core import jkse_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type      req_payload,
   input  logic         space_two,
   input  win_sts_type  win_sts,
   output win_ctl_type  win_ctl,
   output push_type     push,
   output core_sts_type sts
);

   logic      in_valid_ff;
   req_type   in_data_ff;
   phase_type phase_ff;
   phase_type phase_in;
   phase_type phase_proc;
   logic [2:0] hex_ff;
   logic [2:0] hex_in;
   logic       fire;
   logic       main_vld;
   rsp_type    main_rsp;
   logic       stat_vld;
   rsp_type    stat_rsp;
   logic [7:0] c;
   logic       last;
   logic       shift;

   assign fire      = in_valid_ff && space_two;
   assign req_stall = in_valid_ff && !space_two;
   assign c         = in_data_ff.text_byte;
   assign last      = in_data_ff.document_end;

   // Hold the input item until the queue has room for both results
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_payload;
      end
   end

   // Phase step for one byte, then the end-of-document status
   always_comb begin
      phase_proc = phase_ff;
      hex_in     = hex_ff;
      main_vld   = 1'b0;
      main_rsp   = '{value_byte: 8'h00, kind: KIND_DATA, final_item: 1'b0};
      shift      = 1'b0;
      case (phase_ff)
         PH_COLON: begin
            if (c == CHAR_COLON) phase_proc = PH_OPENQ;
         end
         PH_OPENQ: begin
            if (c == CHAR_QUOTE) begin
               phase_proc = PH_VALUE;
            end else if (!is_space(c)) begin
               main_vld   = 1'b1;
               main_rsp   = '{value_byte: 8'h00, kind: KIND_BAD, final_item: 1'b1};
               phase_proc = PH_DONE;
            end
         end
         PH_VALUE: begin
            if (c == CHAR_QUOTE) begin
               main_vld   = 1'b1;
               main_rsp   = '{value_byte: 8'h00, kind: KIND_OK, final_item: 1'b1};
               phase_proc = PH_DONE;
            end else if (c == CHAR_BSLASH) begin
               phase_proc = PH_ESC;
            end else begin
               main_vld = 1'b1;
               main_rsp = '{value_byte: c, kind: KIND_DATA, final_item: 1'b0};
            end
         end
         PH_ESC: begin
            main_vld = 1'b1;
            if (c == CHAR_U) begin
               main_rsp   = '{value_byte: CHAR_QMARK, kind: KIND_DATA, final_item: 1'b0};
               hex_in     = HEX_SKIP;
               phase_proc = PH_HEX;
            end else begin
               main_rsp   = '{value_byte: decode_escape(c), kind: KIND_DATA, final_item: 1'b0};
               phase_proc = PH_VALUE;
            end
         end
         PH_HEX: begin
            if (hex_ff != 3'd0) hex_in = hex_ff - 3'd1;
            if (hex_in == 3'd0) phase_proc = PH_VALUE;
         end
         PH_DONE: begin
         end
         default: begin
            shift      = 1'b1;
            phase_proc = win_sts.match ? PH_COLON : PH_SEARCH;
         end
      endcase

      stat_vld = 1'b0;
      stat_rsp = '{value_byte: 8'h00, kind: KIND_NOTFOUND, final_item: 1'b1};
      phase_in = phase_proc;
      if (last) begin
         if (phase_proc == PH_SEARCH || phase_proc == PH_COLON) begin
            stat_vld = 1'b1;
         end else if (phase_proc != PH_DONE) begin
            stat_vld = 1'b1;
            stat_rsp = '{value_byte: 8'h00, kind: KIND_BAD, final_item: 1'b1};
         end
         phase_in = PH_SEARCH;
         hex_in   = 3'd0;
      end
   end

   // Pack results in order for the queue
   always_comb begin
      push.first  = main_vld ? main_rsp : stat_rsp;
      push.second = stat_rsp;
      push.cnt    = 2'd0;
      if (fire) begin
         push.cnt = {1'b0, main_vld} + {1'b0, stat_vld};
      end
   end

   assign win_ctl.shift = fire && shift;
   assign win_ctl.clear = fire && last;
   assign win_ctl.data  = c;

   assign sts.fire      = fire;
   assign sts.last      = last;
   assign sts.searching = (phase_ff == PH_SEARCH) && (hex_ff == 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
         hex_ff   <= 3'd0;
      end else if (fire) begin
         phase_ff <= phase_in;
         hex_ff   <= hex_in;
      end
   end

endmodule

// ----- rtl/core/jkse_outq.sv -----
`timescale 1ns / 1ps
module jkse_outq import jkse_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  push_type          push,
   output logic              space_two,
   output logic [QCNT_W-1:0] count,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_payload
);

   rsp_type             mem_ff [Q_DEPTH];
   logic [QPTR_W-1:0]   wr_ff;
   logic [QPTR_W-1:0]   wr_in;
   logic [QPTR_W-1:0]   rd_ff;
   logic [QPTR_W-1:0]   rd_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                pop;

   assign pop         = rsp_valid && !rsp_stall;
   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = mem_ff[rd_ff];
   assign space_two   = count_ff <= QCNT_W'(Q_DEPTH - 2);
   assign count       = count_ff;

   // Advance pointers and fill count
   always_comb begin
      wr_in    = wr_ff + QPTR_W'(push.cnt);
      rd_in    = rd_ff + QPTR_W'(pop);
      count_in = count_ff + QCNT_W'(push.cnt) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Store one or two items
   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) begin
         mem_ff[wr_ff] <= push.first;
      end
      if (push.cnt == 2'd2) begin
         mem_ff[wr_ff + 1'b1] <= push.second;
      end
   end

endmodule

// ----- rtl/core/json_key_string_extractor_top.sv -----
// An item is accepted into the input register and processed there; its results are registered
// into the result queue, from which rsp offers them in order.
// Throughput: one item per cycle; an item giving two results takes two queue entries,
// and the four-entry result queue stalls input when fewer than two slots are free.
// Reset (synchronous, active high) clears the control state, the key registers and length.
`timescale 1ns / 1ps
`include "json_key_string_extractor_top_macros.svh"
module json_key_string_extractor_top import jkse_pkg::*; #(
   parameter int MAX_KEY_BYTES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload
);

   logic [CSR_DATA_W-1:0] key_low_ff;
   logic [CSR_DATA_W-1:0] key_high_ff;
   logic [KEY_LEN_W-1:0]  key_len_ff;
   win_ctl_type           win_ctl;
   win_sts_type           win_sts;
   push_type              push;
   core_sts_type          core_sts;
   logic                  space_two;
   logic [QCNT_W-1:0]     q_count;
   logic                  push_any;
   logic                  rsp_final;
   logic                  doc_done;
   logic                  scan_idle;

   // Write configuration registers; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         key_len_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            CSR_KEY_HIGH: key_high_ff <= csr_wdata;
            CSR_KEY_LEN:  key_len_ff  <= csr_wdata[KEY_LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   jkse_window #(
      .MaxKeyBytes(MAX_KEY_BYTES)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .key_all ({key_high_ff, key_low_ff}),
      .key_len (key_len_ff),
      .ctl     (win_ctl),
      .sts     (win_sts)
   );

   jkse_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .space_two   (space_two),
      .win_sts     (win_sts),
      .win_ctl     (win_ctl),
      .push        (push),
      .sts         (core_sts)
   );

   jkse_outq u_outq (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .space_two   (space_two),
      .count       (q_count),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Terms for the checks below
   assign push_any  = (push.cnt != 2'd0);
   assign rsp_final = rsp_valid && rsp_payload.final_item;
   assign doc_done  = core_sts.fire && core_sts.last;
   assign scan_idle = core_sts.searching && win_sts.empty;

   // Queue must have room for every push
   `JKSE_ASSERT_NOW(a_push_room, push_any, q_count <= QCNT_W'(Q_DEPTH - 2), "queue overrun")
   // A final result is never a data byte
   `JKSE_ASSERT_NOW(a_final_status, rsp_final, rsp_payload.kind != KIND_DATA, "final data item")
   // Document end returns the scanner to an empty search
   `JKSE_ASSERT_NEXT(a_doc_restart, doc_done, scan_idle, "state not cleared at document end")

endmodule
